// ===== hdl/npcm_pkg.sv =====
// Shared types, constants and helpers for the nearest palette color match block.
`timescale 1ns / 1ps

package npcm_pkg;

    // Squared distance from black to white; a candidate must lie strictly below it.
    localparam logic [17:0] DIST_BOUND = 18'd195075;

    // Values carried in s_axis_tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One palette entry presented to the distance unit, with its scan markers.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic eligible;
        t_rgb entry;
    } t_probe;

    // Running best match as seen by the controller.
    typedef struct packed {
        logic        done;
        logic        hit;
        logic [17:0] distance;
    } t_match;

    function automatic logic [7:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

// ===== hdl/nearest_palette_color_match.sv =====
// Top level of the nearest palette color match block.
//
//  Channel | Direction | Payload
//  s_axis  | in        | tdata: entry_index[7:0] red[15:8] green[23:16] blue[31:24]; tuser: command
//  m_axis  | out       | tdata: match_index[7:0] match_distance[25:8] zero[31:26]; tuser: found
//  cfg     | in        | i_cfg_wdata: active_entries[8:0], written when i_cfg_we is high
//
// A write beat goes straight into the cell named by its entry index. A query rotates
// the palette ring once past the distance unit, one entry per cycle, before its
// result is loaded into the output register; that ring length sets the query rate.
// Reset clears control state only; palette contents stay undefined until written.
// The input side is ready again as soon as the result is loaded, even while it
// waits on a stalled m_axis; a new result waits until the old one is taken.
`timescale 1ns / 1ps

module nearest_palette_color_match #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // entry_index, red, green, blue from bit 0 up
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // match_index, match_distance, zero pad from bit 0 up
    output logic        m_axis_tuser    // found
);
    import npcm_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_step;
    logic [IDX_W-1:0] n_step;
    logic [8:0]       r_active;
    t_rgb             r_color;

    logic             r_out_valid;
    logic [7:0]       r_out_idx;
    logic [17:0]      r_out_dist;
    logic             r_out_found;

    logic             w_in_accept;
    logic             w_write;
    logic             w_load_out;
    t_rgb             w_in_rgb;
    t_rgb             w_ring [PALETTE_ENTRIES];
    t_probe           w_probe;
    t_match           w_match;
    logic [IDX_W-1:0] w_match_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_write       = w_in_accept && (s_axis_tuser == CMD_WRITE);

    assign w_in_rgb.red   = s_axis_tdata[15:8];
    assign w_in_rgb.green = s_axis_tdata[23:16];
    assign w_in_rgb.blue  = s_axis_tdata[31:24];

    // The ring shifts toward cell zero; after a full turn every entry is home again.
    for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
        npcm_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (r_state == S_SCAN),
            .i_neighbor (w_ring[(k + 1) % PALETTE_ENTRIES]),
            .i_wr_en    (w_write && (32'(s_axis_tdata[7:0]) == k)),
            .i_wr_data  (w_in_rgb),
            .o_entry    (w_ring[k])
        );
    end

    assign w_probe.valid    = (r_state == S_SCAN);
    assign w_probe.first    = (r_step == '0);
    assign w_probe.last     = (r_step == LAST_STEP);
    assign w_probe.eligible = (13'(r_step) < 13'(r_active));
    assign w_probe.entry    = w_ring[0];

    npcm_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_probe (w_probe),
        .i_step  (r_step),
        .i_color (r_color),
        .o_match (w_match),
        .o_index (w_match_idx)
    );

    assign w_load_out = (r_state == S_HOLD) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept && (s_axis_tuser == CMD_QUERY)) begin
                    n_state = S_SCAN;
                    n_step  = '0;
                end
            end
            S_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_match.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_accept) begin
            r_color <= w_in_rgb;
        end
        if (w_load_out) begin
            r_out_found <= w_match.hit;
            r_out_idx   <= w_match.hit ? 8'(w_match_idx) : 8'd0;
            r_out_dist  <= w_match.hit ? w_match.distance : 18'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_dist, r_out_idx};
    assign m_axis_tuser  = r_out_found;

endmodule

// ===== hdl/npcm_cell.sv =====
// One palette cell of the rotating entry ring.
`timescale 1ns / 1ps

module npcm_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  npcm_pkg::t_rgb  i_neighbor,
    input  logic            i_wr_en,
    input  npcm_pkg::t_rgb  i_wr_data,
    output npcm_pkg::t_rgb  o_entry
);
    import npcm_pkg::*;

    t_rgb r_entry;

    // Writes only arrive while the ring is parked, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_neighbor;
        end else if (i_wr_en) begin
            r_entry <= i_wr_data;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/npcm_dist.sv =====
// Two-stage squared distance and running minimum unit at the head of the ring.
`timescale 1ns / 1ps

module npcm_dist #(
    parameter int IDX_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  npcm_pkg::t_probe  i_probe,
    input  logic [IDX_W-1:0]  i_step,
    input  npcm_pkg::t_rgb    i_color,
    output npcm_pkg::t_match  o_match,
    output logic [IDX_W-1:0]  o_index
);
    import npcm_pkg::*;

    logic             r_s1_valid;
    logic             r_s1_first;
    logic             r_s1_last;
    logic             r_s1_elig;
    logic [IDX_W-1:0] r_s1_step;
    logic [15:0]      r_sq_r;
    logic [15:0]      r_sq_g;
    logic [15:0]      r_sq_b;

    logic             r_done;
    logic             r_hit;
    logic [17:0]      r_best;
    logic [IDX_W-1:0] r_best_idx;

    logic [7:0]  w_dr;
    logic [7:0]  w_dg;
    logic [7:0]  w_db;
    logic [17:0] w_sum;
    logic [17:0] w_bound;
    logic        w_take;

    assign w_dr = chan_diff(i_color.red,   i_probe.entry.red);
    assign w_dg = chan_diff(i_color.green, i_probe.entry.green);
    assign w_db = chan_diff(i_color.blue,  i_probe.entry.blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_probe.valid;
        end
        r_s1_first <= i_probe.first;
        r_s1_last  <= i_probe.last;
        r_s1_elig  <= i_probe.eligible;
        r_s1_step  <= i_step;
        r_sq_r     <= 16'(w_dr) * 16'(w_dr);
        r_sq_g     <= 16'(w_dg) * 16'(w_dg);
        r_sq_b     <= 16'(w_db) * 16'(w_db);
    end

    assign w_sum   = 18'(r_sq_r) + 18'(r_sq_g) + 18'(r_sq_b);
    // The first entry of a scan compares against the black-to-white bound.
    assign w_bound = r_s1_first ? DIST_BOUND : r_best;
    assign w_take  = r_s1_elig && (w_sum < w_bound);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_done <= r_s1_valid && r_s1_last;
            if (r_s1_valid) begin
                if (r_s1_first) begin
                    r_hit <= w_take;
                end else if (w_take) begin
                    r_hit <= 1'b1;
                end
            end
        end
        if (r_s1_valid) begin
            if (w_take) begin
                r_best     <= w_sum;
                r_best_idx <= r_s1_step;
            end else if (r_s1_first) begin
                r_best <= DIST_BOUND;
            end
        end
    end

    assign o_match.done     = r_done;
    assign o_match.hit      = r_hit;
    assign o_match.distance = r_best;
    assign o_index          = r_best_idx;

endmodule
